### hdl/pacc_pkg.sv
package pacc_pkg;

  localparam int unsigned IDX_W  = 12;
  localparam int unsigned PIX_N  = 1 << IDX_W;
  localparam int unsigned CNT_W  = 13;
  localparam int unsigned CFG_W  = 13;
  localparam int unsigned CIDX_W = 2;
  localparam int unsigned ACC_W  = 24;
  localparam int unsigned CH_W   = 16;
  localparam int unsigned INV_W  = 24;
  localparam int unsigned LANES  = 4;

  localparam logic [CNT_W-1:0] MAX_PIXELS   = CNT_W'(4096);
  localparam logic [CNT_W-1:0] SAMPLE_LIMIT = CNT_W'(4096);

  localparam logic [CFG_W-1:0] MAX_SAMPLES_RST = CFG_W'(16);
  localparam logic [CFG_W-1:0] PIXEL_COUNT_RST = CFG_W'(4096);

  // register indexes
  localparam logic [CIDX_W-1:0] REG_ACC_ENABLE  = CIDX_W'(0);
  localparam logic [CIDX_W-1:0] REG_MAX_SAMPLES = CIDX_W'(1);
  localparam logic [CIDX_W-1:0] REG_PIXEL_COUNT = CIDX_W'(2);

  // word kinds
  localparam logic KIND_PIXEL   = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  typedef enum logic [1:0] {
    MODE_PASS,
    MODE_COPY,
    MODE_BLEND
  } pacc_mode_e;

  typedef struct packed {
    logic                   kind;
    logic [IDX_W-1:0]       px_idx;
    logic signed [CH_W-1:0] red_in;
    logic signed [CH_W-1:0] green_in;
    logic signed [CH_W-1:0] blue_in;
    logic signed [CH_W-1:0] alpha_in;
    logic                   frame_end;
  } pacc_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic       last_pixel;
  } pacc_out_t;

  typedef struct packed {
    logic       load;
    logic       mul;
    logic       wb;
    pacc_mode_e mode;
  } pacc_ctl_t;

endpackage

### hdl/pacc_ram.sv
module pacc_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/pacc_recip.sv
module pacc_recip
  import pacc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [CNT_W-1:0] divisor_i,
  output logic             busy_o,
  output logic [INV_W-1:0] inv_o
);

  // restoring divider, one quotient bit a cycle over a 25 bit numerator
  localparam int unsigned NUM_W = INV_W + 1;

  logic                       busy_q;
  logic [4:0]                 cnt_q;
  logic [CNT_W-1:0]           rem_q;
  logic [CNT_W-1:0]           dvs_q;
  logic [NUM_W-1:0]           sh_q;
  logic [INV_W-1:0]           inv_q;
  logic [CNT_W:0]             trial;
  logic [CNT_W:0]             diff;
  logic                       qbit;
  logic [NUM_W-1:0]           sh_d;

  always_comb begin
    trial = {rem_q, sh_q[NUM_W-1]};
    diff  = trial - {1'b0, dvs_q};
    qbit  = (trial >= {1'b0, dvs_q});
    sh_d  = {sh_q[NUM_W-2:0], qbit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 5'd1;
      if (cnt_q == 5'(NUM_W - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      // numerator 2^24 + n1/2
      sh_q  <= {1'b1, {(NUM_W-1){1'b0}}} | NUM_W'(divisor_i[CNT_W-1:1]);
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      sh_q  <= sh_d;
      rem_q <= qbit ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      if (cnt_q == 5'(NUM_W - 1)) begin
        inv_q <= sh_d[INV_W-1:0];
      end
    end
  end

  assign busy_o = busy_q;
  assign inv_o  = inv_q;

endmodule

### hdl/pacc_lane.sv
module pacc_lane
  import pacc_pkg::*;
(
  input  logic                   clk_i,
  input  pacc_ctl_t              ctl_i,
  input  logic [IDX_W-1:0]       idx_i,
  input  logic signed [CH_W-1:0] pix_i,
  input  logic [INV_W-1:0]       inv_i,
  output logic [7:0]             byte_o
);

  pacc_mode_e               mode_q;
  logic [IDX_W-1:0]         idx_q;
  logic signed [ACC_W-1:0]  pix_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [50:0]       prod_q;
  logic signed [ACC_W-1:0]  val_q;

  logic [ACC_W-1:0]         rdata;
  logic signed [ACC_W:0]    diff;
  logic signed [25:0]       inv_s;
  logic signed [50:0]       prod_d;
  logic signed [50:0]       rnd;
  logic signed [26:0]       step;
  logic signed [26:0]       sum;
  logic signed [ACC_W-1:0]  sat;
  logic signed [ACC_W-1:0]  val_d;
  logic                     we;
  logic signed [33:0]       qx;

  pacc_ram #(
    .WIDTH (ACC_W),
    .DEPTH (PIX_N)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (idx_q),
    .wdata_i (val_d),
    .re_i    (ctl_i.load),
    .raddr_i (idx_i),
    .rdata_o (rdata)
  );

  always_comb begin
    diff   = {pix_q[ACC_W-1], pix_q} - {rdata[ACC_W-1], rdata};
    inv_s  = {2'b00, inv_i};
    prod_d = diff * inv_s;
  end

  // blend step floor((d*inv + 2^23) / 2^24), then saturate
  always_comb begin
    rnd  = prod_q + 51'sd8388608;
    step = rnd[50:24];
    sum  = {{3{acc_q[ACC_W-1]}}, acc_q} + step;
    if (sum > 27'sd8388607) begin
      sat = 24'sh7fffff;
    end else if (sum < -27'sd8388608) begin
      sat = 24'sh800000;
    end else begin
      sat = sum[ACC_W-1:0];
    end
    unique case (mode_q)
      MODE_BLEND: val_d = sat;
      default:    val_d = pix_q;
    endcase
    we = ctl_i.wb && (mode_q != MODE_PASS);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      mode_q <= ctl_i.mode;
      idx_q  <= idx_i;
      pix_q  <= {pix_i, 8'h00};
    end
    if (ctl_i.mul) begin
      acc_q  <= rdata;
      prod_q <= prod_d;
    end
    if (ctl_i.wb) begin
      val_q <= val_d;
    end
  end

  // v*255 + 2^19, clamp to a byte
  always_comb begin
    qx = ({{2{val_q[ACC_W-1]}}, val_q, 8'h00} - 34'(val_q)) + 34'sd524288;
    if (qx < 0) begin
      byte_o = 8'd0;
    end else if (qx[33:20] > 14'd255) begin
      byte_o = 8'd255;
    end else begin
      byte_o = qx[27:20];
    end
  end

endmodule

### hdl/progressive_pixel_accumulator_core.sv
// channel | direction | handshake             | payload
// in      | input     | in_valid_i/in_stall_o | pacc_in_t: kind, index, rgba q3.12, frame_end
// out     | output    | out_valid_o/out_stall_i | pacc_out_t: rgba bytes, last_pixel
// cfg     | input     | cfg_we_i              | cfg_idx_i, cfg_data_i
//
// a pixel word goes through accept with store read, multiply, write back,
// then the merge into the output register; a restart word only clears the
// count. a frame end that advances the count starts the reciprocal divider,
// which holds off new words while busy. reset initialises the count and the
// control registers; the store is not cleared and needs no sweep. a stalled
// result waits in the output register while the next word is already being worked on.
module progressive_pixel_accumulator_core
  import pacc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pacc_in_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output pacc_out_t         out_data_o,
  input  logic              cfg_we_i,
  input  logic [CIDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_data_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_WB,
    ST_OUT
  } state_e;

  state_e           state_q;
  logic             en_q;
  logic [CFG_W-1:0] max_q;
  logic [CFG_W-1:0] npix_q;
  logic [CNT_W-1:0] count_q;
  logic             last_q;
  logic             out_valid_q;
  pacc_out_t        out_q;

  logic [CNT_W-1:0] eff_max;
  logic [CNT_W-1:0] eff_pix;
  logic             accum;
  logic             in_range;
  logic             accept;
  logic             pix_word;
  logic             bump;
  logic             recip_busy;
  logic [INV_W-1:0] inv;
  logic             out_free;
  pacc_ctl_t        ctl;
  logic signed [CH_W-1:0] chan [LANES];
  logic [7:0]       lane_byte [LANES];

  always_comb begin
    if (max_q == '0) begin
      eff_max = CNT_W'(1);
    end else if (max_q > SAMPLE_LIMIT) begin
      eff_max = SAMPLE_LIMIT;
    end else begin
      eff_max = max_q;
    end
    if (npix_q == '0) begin
      eff_pix = CNT_W'(1);
    end else if (npix_q > MAX_PIXELS) begin
      eff_pix = MAX_PIXELS;
    end else begin
      eff_pix = npix_q;
    end
    accum    = en_q && (count_q < eff_max);
    in_range = {1'b0, in_data_i.px_idx} < eff_pix;
    accept   = in_valid_i && !in_stall_o;
    pix_word = accept && (in_data_i.kind == KIND_PIXEL);
    bump     = pix_word && accum && in_data_i.frame_end;
    out_free = !out_valid_q || !out_stall_i;

    ctl.load = pix_word;
    ctl.mul  = (state_q == ST_MUL);
    ctl.wb   = (state_q == ST_WB);
    if (accum && in_range) begin
      ctl.mode = (count_q == '0) ? MODE_COPY : MODE_BLEND;
    end else begin
      ctl.mode = MODE_PASS;
    end

    chan[0] = in_data_i.red_in;
    chan[1] = in_data_i.green_in;
    chan[2] = in_data_i.blue_in;
    chan[3] = in_data_i.alpha_in;
  end

  assign in_stall_o = (state_q != ST_IDLE) || recip_busy;

  pacc_recip u_recip (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (bump),
    .divisor_i (count_q + CNT_W'(2)),
    .busy_o    (recip_busy),
    .inv_o     (inv)
  );

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    pacc_lane u_lane (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .idx_i  (in_data_i.px_idx),
      .pix_i  (chan[g]),
      .inv_i  (inv),
      .byte_o (lane_byte[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      en_q        <= 1'b0;
      max_q       <= MAX_SAMPLES_RST;
      npix_q      <= PIXEL_COUNT_RST;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != ST_OUT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (in_data_i.kind == KIND_RESTART) begin
              count_q <= '0;
            end else begin
              state_q <= ST_MUL;
              if (bump) begin
                count_q <= count_q + CNT_W'(1);
              end
            end
          end
        end
        ST_MUL: state_q <= ST_WB;
        ST_WB:  state_q <= ST_OUT;
        ST_OUT: begin
          // merge the lane bytes into one word
          if (out_free) begin
            out_q.red_out    <= lane_byte[0];
            out_q.green_out  <= lane_byte[1];
            out_q.blue_out   <= lane_byte[2];
            out_q.alpha_out  <= lane_byte[3];
            out_q.last_pixel <= last_q;
            out_valid_q      <= 1'b1;
            state_q          <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_ACC_ENABLE: begin
            en_q <= cfg_data_i[0];
            if (!cfg_data_i[0]) begin
              count_q <= '0;
            end
          end
          REG_MAX_SAMPLES: max_q <= cfg_data_i;
          REG_PIXEL_COUNT: begin
            npix_q  <= cfg_data_i;
            count_q <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_word) begin
      last_q <= in_data_i.frame_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
